/* src/rbb_pkg.sv */
// Shared types, constants and helpers for the row box blur block.
`timescale 1ns / 1ps
`default_nettype none

package rbb_pkg;

   // Fixed field widths of the pixel stream.
   localparam int PIX_W    = 24;
   localparam int CHAN_W   = 8;
   localparam int CHANNELS = 3;
   localparam int RAD_W    = 6;
   localparam int POS_W    = 12;
   localparam int STEP_W   = $clog2(CHAN_W);

   // A row is cut off at this many pixels.
   localparam int ROW_WIDTH_MAX = 4096;

   // Radius setting after reset.
   localparam logic [RAD_W-1:0] RESET_RADIUS = 6'd8;

   // One classified pixel, handed from the front end to the back end.
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] first;
      logic [RAD_W-1:0] radius;
      logic             ends;
      logic             emit;
   } job_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOOKUP,
      BK_TRIM,
      BK_DIVIDE,
      BK_EMIT
   } back_state_type;

   // Channel idx of a packed pixel: 0 is red, 1 green, 2 blue.
   function automatic logic [CHAN_W-1:0] channel_of(input logic [PIX_W-1:0] pix,
                                                    input int idx);
      return pix[CHAN_W*(CHANNELS-1-idx) +: CHAN_W];
   endfunction

endpackage

`default_nettype wire

/* src/rbb_front.sv */
// Front end: radius register, row position tracking and pixel classification.
`timescale 1ns / 1ps
`default_nettype none

module rbb_front #(
   parameter int MAX_RADIUS = 63
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [rbb_pkg::RAD_W-1:0] csr_blur_radius,
   input  logic                      push,
   input  logic [rbb_pkg::PIX_W-1:0] pixel_rgb,
   input  logic                      row_end,
   input  logic                      job_full,
   output logic                      job_push,
   output rbb_pkg::job_type          job
);
   import rbb_pkg::*;

   logic [RAD_W-1:0] blur_radius_ff, blur_radius_in;
   logic [RAD_W-1:0] active_ff, active_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [RAD_W-1:0] clipped;
   logic [RAD_W-1:0] radius_use;
   logic             ends;
   logic             reach;

   // The radius is clipped and latched at the first pixel of each row.
   assign clipped    = (blur_radius_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                              : blur_radius_ff;
   assign radius_use = (pos_ff == '0) ? clipped : active_ff;

   // A row ends on the marker or when it reaches the maximum width.
   assign ends  = row_end || (pos_ff == POS_W'(ROW_WIDTH_MAX - 1));
   assign reach = pos_ff >= POS_W'(radius_use);

   assign job_push = push && !job_full;

   // Classify the beat: which output positions it releases.
   always_comb begin
      job.pixel  = pixel_rgb;
      job.pos    = pos_ff;
      job.radius = radius_use;
      job.ends   = ends;
      job.emit   = reach || ends;
      job.first  = reach ? (pos_ff - POS_W'(radius_use)) : '0;
   end

   // Next values of the front end registers.
   always_comb begin
      blur_radius_in = csr_wr_en ? csr_blur_radius : blur_radius_ff;
      active_in      = job_push ? radius_use : active_ff;
      pos_in         = pos_ff;
      if (job_push) begin
         pos_in = ends ? '0 : (pos_ff + POS_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blur_radius_ff <= RESET_RADIUS;
         active_ff      <= RESET_RADIUS;
         pos_ff         <= '0;
      end else begin
         blur_radius_ff <= blur_radius_in;
         active_ff      <= active_in;
         pos_ff         <= pos_in;
      end
   end

endmodule

`default_nettype wire

/* src/rbb_job_fifo.sv */
// Short queue of classified pixels between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module rbb_job_fifo #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbb_pkg::job_type job_in,
   output logic             full,
   input  logic             pop,
   output rbb_pkg::job_type job_out,
   output logic             empty
);
   import rbb_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type       slots_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign job_out = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : (wr_ptr_ff + AW'(1));
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : (rd_ptr_ff + AW'(1));
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

`default_nettype wire

/* src/rbb_back.sv */
// Back end: pixel ring, running sums, serial divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module rbb_back #(
   parameter int MAX_RADIUS = 63
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_empty,
   input  rbb_pkg::job_type          job,
   output logic                      job_pop,
   output logic                      empty,
   input  logic                      pop,
   output logic [rbb_pkg::PIX_W-1:0] blurred_rgb,
   output logic                      last_of_run,
   output logic                      end_of_row
);
   import rbb_pkg::*;

   localparam int RING_AW    = $clog2(2 * MAX_RADIUS + 2);
   localparam int RING_DEPTH = 1 << RING_AW;
   localparam int CNT_W      = $clog2(2 * MAX_RADIUS + 2);
   localparam int SUM_W      = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
   localparam int DIV_W      = CNT_W + CHAN_W - 1;
   localparam int CMP_W      = (SUM_W > DIV_W) ? SUM_W : DIV_W;

   back_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  x_ff, x_in;
   logic [POS_W-1:0]  last_ff, last_in;
   logic [RAD_W-1:0]  radius_ff, radius_in;
   logic              ends_ff, ends_in;
   logic [SUM_W-1:0]  sum_ff [CHANNELS];
   logic [SUM_W-1:0]  sum_in [CHANNELS];
   logic [SUM_W-1:0]  rem_ff [CHANNELS];
   logic [SUM_W-1:0]  rem_in [CHANNELS];
   logic [CHAN_W-1:0] quo_ff [CHANNELS];
   logic [CHAN_W-1:0] quo_in [CHANNELS];
   logic [SUM_W-1:0]  trim_sum [CHANNELS];
   logic [DIV_W-1:0]  divisor_ff, divisor_in;
   logic [PIX_W-1:0]  ring_mem [RING_DEPTH];
   logic [PIX_W-1:0]  rd_data_ff;
   logic              out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]  out_rgb_ff, out_rgb_in;
   logic              out_last_ff, out_last_in;
   logic              out_end_ff, out_end_in;

   logic              ring_rd;
   logic              div_load;
   logic              div_step;
   logic              out_load;
   logic              slot_free;
   logic              last_x;
   logic              do_trim;
   logic [POS_W-1:0]  start;
   logic [POS_W-1:0]  count;
   logic [POS_W-1:0]  trim_pos;

   assign slot_free = !out_valid_ff || pop;
   assign last_x    = (x_ff == last_ff);

   // Window of the current output position, clipped at the left edge.
   assign do_trim  = x_ff > POS_W'(radius_ff);
   assign start    = (x_ff >= POS_W'(radius_ff)) ? (x_ff - POS_W'(radius_ff)) : '0;
   assign count    = pos_ff - start + POS_W'(1);
   assign trim_pos = x_ff - POS_W'(radius_ff) - POS_W'(1);

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!job_empty) begin
               state_in = job.emit ? BK_LOOKUP : BK_IDLE;
            end
         end
         BK_LOOKUP: state_in = BK_TRIM;
         BK_TRIM:   state_in = BK_DIVIDE;
         BK_DIVIDE: begin
            if (step_ff == STEP_W'(CHAN_W - 1)) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (slot_free) begin
               state_in = last_x ? BK_IDLE : BK_LOOKUP;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Sequencer control outputs.
   always_comb begin
      job_pop  = 1'b0;
      ring_rd  = 1'b0;
      div_load = 1'b0;
      div_step = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         BK_IDLE:   job_pop  = !job_empty;
         BK_LOOKUP: ring_rd  = 1'b1;
         BK_TRIM:   div_load = 1'b1;
         BK_DIVIDE: div_step = 1'b1;
         BK_EMIT:   out_load = slot_free;
         default:   job_pop  = 1'b0;
      endcase
   end

   // The pixel leaving the window on the left is taken off the sums.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         trim_sum[c] = do_trim ? (sum_ff[c] - SUM_W'(channel_of(rd_data_ff, c)))
                               : sum_ff[c];
      end
   end

   // Datapath next values.
   always_comb begin
      pos_in     = pos_ff;
      x_in       = x_ff;
      last_in    = last_ff;
      radius_in  = radius_ff;
      ends_in    = ends_ff;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      out_rgb_in  = out_rgb_ff;
      out_last_in = out_last_ff;
      out_end_in  = out_end_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         sum_in[c] = sum_ff[c];
         rem_in[c] = rem_ff[c];
         quo_in[c] = quo_ff[c];
      end

      if (job_pop) begin
         // Take a new pixel into the sums; a row start clears them.
         pos_in    = job.pos;
         radius_in = job.radius;
         ends_in   = job.ends;
         x_in      = job.first;
         last_in   = job.ends ? job.pos : (job.pos - POS_W'(job.radius));
         for (int c = 0; c < CHANNELS; c++) begin
            sum_in[c] = ((job.pos == '0) ? '0 : sum_ff[c])
                        + SUM_W'(channel_of(job.pixel, c));
         end
      end

      if (div_load) begin
         // Start the divider on the trimmed sums and the window size.
         for (int c = 0; c < CHANNELS; c++) begin
            sum_in[c] = trim_sum[c];
            rem_in[c] = trim_sum[c];
            quo_in[c] = '0;
         end
         divisor_in = {CNT_W'(count), {(CHAN_W - 1){1'b0}}};
         step_in    = '0;
      end

      if (div_step) begin
         // One quotient bit per channel per cycle, restoring division.
         for (int c = 0; c < CHANNELS; c++) begin
            if (CMP_W'(rem_ff[c]) >= CMP_W'(divisor_ff)) begin
               rem_in[c] = rem_ff[c] - SUM_W'(divisor_ff);
               quo_in[c] = {quo_ff[c][CHAN_W-2:0], 1'b1};
            end else begin
               quo_in[c] = {quo_ff[c][CHAN_W-2:0], 1'b0};
            end
         end
         divisor_in = divisor_ff >> 1;
         step_in    = step_ff + STEP_W'(1);
      end

      if (out_load) begin
         out_rgb_in  = {quo_ff[0], quo_ff[1], quo_ff[2]};
         out_last_in = last_x;
         out_end_in  = ends_ff && (x_ff == pos_ff);
         x_in        = x_ff + POS_W'(1);
      end
   end

   // Result register occupancy.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      x_ff        <= x_in;
      last_ff     <= last_in;
      radius_ff   <= radius_in;
      ends_ff     <= ends_in;
      step_ff     <= step_in;
      divisor_ff  <= divisor_in;
      out_rgb_ff  <= out_rgb_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
      for (int c = 0; c < CHANNELS; c++) begin
         sum_ff[c] <= sum_in[c];
         rem_ff[c] <= rem_in[c];
         quo_ff[c] <= quo_in[c];
      end
   end

   // Ring of recent pixels: written on intake, read for the left edge.
   always_ff @(posedge clock) begin
      if (job_pop) begin
         ring_mem[job.pos[RING_AW-1:0]] <= job.pixel;
      end
      if (ring_rd) begin
         rd_data_ff <= ring_mem[trim_pos[RING_AW-1:0]];
      end
   end

   assign empty       = !out_valid_ff;
   assign blurred_rgb = out_rgb_ff;
   assign last_of_run = out_last_ff;
   assign end_of_row  = out_end_ff;

`ifndef SYNTHESIS
   // A released run never starts past its own last position.
   assert property (@(posedge clock) disable iff (reset)
      (job_pop && job.emit) |=> (x_ff <= last_ff))
      else $error("run starts past its last position");

   // A result is never produced beyond the end of its run.
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> (x_ff <= last_ff))
      else $error("result beyond end of run");

   // The window holds at least one pixel and at most two radii plus one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_TRIM) |->
         (count != '0 && count <= (POS_W'(2) * POS_W'(radius_ff) + POS_W'(1))))
      else $error("window size out of range");
`endif

endmodule

`default_nettype wire

/* src/row_box_blur_rgb.sv */
// Top level of the horizontal RGB box blur over a pixel row.
//
//   channel   direction   handshake                      payload
//   req       in          push / full                    req_pixel_rgb, req_row_end
//   rsp       out         empty / pop                    rsp_blurred_rgb, rsp_last_of_run,
//                                                        rsp_end_of_row
//   csr       in          csr_wr_en (always taken)       csr_blur_radius
//
// A pixel that releases no result is only taken in by the idle state; each result
// passes through a ring read, a trim of the sums and eight serial divider steps,
// then a load of the result register, which waits while the previous result is not popped.
// The back end takes no new pixel before its run is done; at a row end the run
// ends at the row's last pixel. Reset is synchronous; the ring needs no clearing pass.
// The job queue keeps taking pixels while the back end divides or the result
// waits, and full rises only when JOB_DEPTH pixels are waiting.
`timescale 1ns / 1ps
`default_nettype none

module row_box_blur_rgb #(
   parameter int MAX_RADIUS = 63,
   parameter int JOB_DEPTH  = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [rbb_pkg::RAD_W-1:0] csr_blur_radius,
   input  logic                      push,
   output logic                      full,
   input  logic [rbb_pkg::PIX_W-1:0] req_pixel_rgb,
   input  logic                      req_row_end,
   output logic                      empty,
   input  logic                      pop,
   output logic [rbb_pkg::PIX_W-1:0] rsp_blurred_rgb,
   output logic                      rsp_last_of_run,
   output logic                      rsp_end_of_row
);
   import rbb_pkg::*;

   job_type front_job;
   job_type back_job;
   logic    job_push;
   logic    job_full;
   logic    job_pop;
   logic    job_empty;

   assign full = job_full;

   // Front end classifies each beat.
   rbb_front #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_blur_radius (csr_blur_radius),
      .push            (push),
      .pixel_rgb       (req_pixel_rgb),
      .row_end         (req_row_end),
      .job_full        (job_full),
      .job_push        (job_push),
      .job             (front_job)
   );

   // Queue between the two halves.
   rbb_job_fifo #(
      .DEPTH (JOB_DEPTH)
   ) u_job_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .job_in  (front_job),
      .full    (job_full),
      .pop     (job_pop),
      .job_out (back_job),
      .empty   (job_empty)
   );

   // Back end computes the averages.
   rbb_back #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_empty   (job_empty),
      .job         (back_job),
      .job_pop     (job_pop),
      .empty       (empty),
      .pop         (pop),
      .blurred_rgb (rsp_blurred_rgb),
      .last_of_run (rsp_last_of_run),
      .end_of_row  (rsp_end_of_row)
   );

endmodule

`default_nettype wire
